[src/lfu_replacement_table_core_macros.svh]
// Assertion macros shared by the checker.
`ifndef LFU_REPLACEMENT_TABLE_CORE_MACROS_SVH
`define LFU_REPLACEMENT_TABLE_CORE_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define LFU_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define LFU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/lfu_pkg.sv]
// Package with types and constants of the LFU replacement table.
package lfu_pkg;
    localparam int ENTRIES    = 64;
    localparam int COUNT_BITS = 16;
    localparam int IDX_BITS   = $clog2(ENTRIES);
    localparam int CNT_BITS   = $clog2(ENTRIES + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] FUNC_GET  = 2'd0;
    localparam logic [1:0] FUNC_SET  = 2'd1;
    localparam logic [1:0] FUNC_TAKE = 2'd2;

    // Width of one stored entry: key, payload, count, stamp.
    localparam int ENTRY_W = 32 + 64 + COUNT_BITS + 32;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key_tag;
        logic [63:0] write_data;
        logic [15:0] start_count;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [63:0] read_data;
        logic        evicted;
        logic [31:0] evicted_key;
        logic [63:0] evicted_data;
    } out_item_t;

    typedef struct packed {
        logic [31:0]           key;
        logic [63:0]           payload;
        logic [COUNT_BITS-1:0] uses;
        logic [31:0]           order;
    } entry_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic                load;      // capture the input item
        logic                scan_rd;   // issue read of scan address
        logic [IDX_BITS-1:0] scan_addr;
        logic                scan_eval; // evaluate data of previous read
        logic [IDX_BITS-1:0] eval_addr;
        logic                fin_rd;    // read chosen slot (victim/hit)
        logic                commit;    // apply update and build result
    } dp_cmd_t;

    // Datapath to controller status.
    typedef struct packed {
        logic hit_found;
    } dp_stat_t;
endpackage

[src/lfu_ram.sv]
// Generic single-port-write, single-read RAM with registered read.
module lfu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[src/lfu_datapath.sv]
// Datapath: entry storage, scan compare, victim search and result build.
module lfu_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [6:0]        capacity,
    input  lfu_pkg::in_item_t in_item,
    input  lfu_pkg::dp_cmd_t  cmd,
    output lfu_pkg::dp_stat_t stat,
    output lfu_pkg::out_item_t result
);
    import lfu_pkg::*;

    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [31:0]         order_counter_reg, order_counter_next;
    logic [CNT_BITS-1:0] occ_reg, occ_next;
    in_item_t            item_reg;
    logic                hit_reg, hit_next;
    logic [IDX_BITS-1:0] hit_idx_reg, hit_idx_next;
    logic                best_ok_reg, best_ok_next;
    logic [IDX_BITS-1:0] best_idx_reg, best_idx_next;
    logic [COUNT_BITS-1:0] best_uses_reg, best_uses_next;
    logic [31:0]         best_age_reg, best_age_next;
    logic                free_ok_reg, free_ok_next;
    logic [IDX_BITS-1:0] free_idx_reg, free_idx_next;
    out_item_t           result_reg, result_next;

    logic                ram_we;
    logic [IDX_BITS-1:0] ram_waddr, ram_raddr;
    entry_t              ram_wdata, ram_rdata;

    logic [31:0]         age;
    logic [CNT_BITS-1:0] cap_eff;
    logic                full;
    logic [IDX_BITS-1:0] ins_idx;
    logic                ins_ok;
    logic [COUNT_BITS-1:0] start_eff;

    lfu_ram #(.WIDTH(ENTRY_W), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Read address: scan address, else the slot chosen for the final step.
    always_comb
    begin
        if (cmd.scan_rd)
        begin
            ram_raddr = cmd.scan_addr;
        end
        else if (hit_reg)
        begin
            ram_raddr = hit_idx_reg;
        end
        else
        begin
            ram_raddr = best_idx_reg;
        end
    end

    assign age = order_counter_reg - ram_rdata.order;

    // Effective capacity, clamped into one to ENTRIES.
    always_comb
    begin
        if (capacity == 7'd0)
        begin
            cap_eff = CNT_BITS'(1);
        end
        else if (32'(capacity) > ENTRIES)
        begin
            cap_eff = CNT_BITS'(ENTRIES);
        end
        else
        begin
            cap_eff = CNT_BITS'(capacity);
        end
    end

    assign full = (occ_reg >= cap_eff) && best_ok_reg;

    // Start count with zero raised to one.
    assign start_eff = (item_reg.start_count == 16'd0) ? COUNT_BITS'(1)
                                                       : COUNT_BITS'(item_reg.start_count);

    // Insert slot: evicted slot if there is no free slot or it is lower than the first free slot.
    always_comb
    begin
        ins_ok  = free_ok_reg;
        ins_idx = free_idx_reg;
        if (full && (!free_ok_reg || best_idx_reg < free_idx_reg))
        begin
            ins_ok  = 1'b1;
            ins_idx = best_idx_reg;
        end
    end

    // Scan evaluation, update commit and result construction.
    always_comb
    begin
        hit_next           = hit_reg;
        hit_idx_next       = hit_idx_reg;
        best_ok_next       = best_ok_reg;
        best_idx_next      = best_idx_reg;
        best_uses_next     = best_uses_reg;
        best_age_next      = best_age_reg;
        free_ok_next       = free_ok_reg;
        free_idx_next      = free_idx_reg;
        valid_next         = valid_reg;
        occ_next           = occ_reg;
        order_counter_next = order_counter_reg;
        result_next        = result_reg;
        ram_we             = 1'b0;
        ram_waddr          = hit_idx_reg;
        ram_wdata          = ram_rdata;

        if (cmd.load)
        begin
            hit_next     = 1'b0;
            best_ok_next = 1'b0;
            free_ok_next = 1'b0;
        end

        if (cmd.scan_eval)
        begin
            if (valid_reg[cmd.eval_addr])
            begin
                if (!hit_reg && ram_rdata.key == item_reg.key_tag)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmd.eval_addr;
                end
                if (!best_ok_reg || ram_rdata.uses < best_uses_reg ||
                    (ram_rdata.uses == best_uses_reg && age > best_age_reg))
                begin
                    best_ok_next   = 1'b1;
                    best_idx_next  = cmd.eval_addr;
                    best_uses_next = ram_rdata.uses;
                    best_age_next  = age;
                end
            end
            else if (!free_ok_reg)
            begin
                free_ok_next  = 1'b1;
                free_idx_next = cmd.eval_addr;
            end
        end

        if (cmd.commit)
        begin
            result_next = '0;
            if (hit_reg)
            begin
                case (item_reg.func)
                    FUNC_GET:
                    begin
                        result_next.hit       = 1'b1;
                        result_next.read_data = ram_rdata.payload;
                        ram_we    = 1'b1;
                        ram_wdata.uses = (ram_rdata.uses < COUNT_MAX) ? ram_rdata.uses + 1'b1
                                                                      : ram_rdata.uses;
                        ram_wdata.order    = order_counter_reg;
                        order_counter_next = order_counter_reg + 32'd1;
                    end
                    FUNC_SET:
                    begin
                        result_next.hit = 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata.uses = (ram_rdata.uses < COUNT_MAX) ? ram_rdata.uses + 1'b1
                                                                      : ram_rdata.uses;
                        ram_wdata.order    = order_counter_reg;
                        ram_wdata.payload  = item_reg.write_data;
                        order_counter_next = order_counter_reg + 32'd1;
                    end
                    FUNC_TAKE:
                    begin
                        result_next.hit        = 1'b1;
                        result_next.read_data  = ram_rdata.payload;
                        valid_next[hit_idx_reg] = 1'b0;
                        occ_next = occ_reg - 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (item_reg.func == FUNC_SET)
            begin
                if (full)
                begin
                    result_next.evicted      = 1'b1;
                    result_next.evicted_key  = ram_rdata.key;
                    result_next.evicted_data = ram_rdata.payload;
                    valid_next[best_idx_reg] = 1'b0;
                end
                if (ins_ok)
                begin
                    valid_next[ins_idx] = 1'b1;
                    ram_we    = 1'b1;
                    ram_waddr = ins_idx;
                    ram_wdata.key     = item_reg.key_tag;
                    ram_wdata.payload = item_reg.write_data;
                    ram_wdata.uses    = start_eff;
                    ram_wdata.order   = order_counter_reg;
                    order_counter_next = order_counter_reg + 32'd1;
                end
                occ_next = occ_reg - CNT_BITS'(full) + CNT_BITS'(ins_ok);
            end
        end
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= '0;
            order_counter_reg <= '0;
            occ_reg           <= '0;
        end
        else
        begin
            valid_reg         <= valid_next;
            order_counter_reg <= order_counter_next;
            occ_reg           <= occ_next;
        end
    end

    // Scan and payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        hit_reg       <= hit_next;
        hit_idx_reg   <= hit_idx_next;
        best_ok_reg   <= best_ok_next;
        best_idx_reg  <= best_idx_next;
        best_uses_reg <= best_uses_next;
        best_age_reg  <= best_age_next;
        free_ok_reg   <= free_ok_next;
        free_idx_reg  <= free_idx_next;
        result_reg    <= result_next;
    end

    assign stat.hit_found = hit_reg;
    assign result = result_reg;
endmodule

[src/lfu_ctrl.sv]
// Controller: sequences the scan, final read, commit and handshakes.
module lfu_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  lfu_pkg::dp_stat_t stat,
    output lfu_pkg::dp_cmd_t cmd
);
    import lfu_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_FIN, S_WAIT, S_COMMIT, S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_BITS:0]   cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // Next state, counter and commands.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.scan_addr  = cnt_reg[IDX_BITS-1:0];
        cmd.eval_addr  = IDX_BITS'(cnt_reg - 1'b1);
        in_ready       = (state_reg == S_IDLE) && !out_valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_rd   = (cnt_reg < (IDX_BITS+1)'(ENTRIES));
                cmd.scan_eval = (cnt_reg != '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == (IDX_BITS+1)'(ENTRIES))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.fin_rd = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.commit     = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (stat.hit_found && 1'b0)
        begin
            state_next = S_IDLE;
        end
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

[src/lfu_replacement_table_core.sv]
// LFU replacement table: 64-entry scan in RAM.
// Flow: after acceptance, one RAM read per entry for the key and victim scan,
// then one read of the chosen slot and a commit, after which the result is valid.
// A new item is taken only once the previous result has been taken.
// Reset: asynchronous active-low rst_n empties the table, zeroes the stamp
// counter and sets capacity to 64; no clearing pass is needed.
module lfu_replacement_table_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lfu_pkg::in_item_t   in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output lfu_pkg::out_item_t  out_item,
    input  logic                cfg_we,
    input  logic [6:0]          cfg_wdata
);
    import lfu_pkg::*;

    logic [6:0] capacity_reg;
    dp_cmd_t    cmd;
    dp_stat_t   stat;

    // Capacity register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= 7'd64;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    lfu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lfu_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .capacity (capacity_reg),
        .in_item  (in_item),
        .cmd      (cmd),
        .stat     (stat),
        .result   (out_item)
    );
endmodule

[src/lfu_checker.sv]
// Port-level checker for the LFU replacement table, bound to the top level.
`include "lfu_replacement_table_core_macros.svh"
module lfu_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input lfu_pkg::out_item_t out_item
);
    import lfu_pkg::*;

    // No new item is taken while a result waits.
    `LFU_ASSERT_IMP(a_no_accept_while_out, out_valid, !in_ready, "input taken while result pending")
    // A result holds until it is taken.
    `LFU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped")
    // An accepted item cannot produce a result in the next cycle.
    `LFU_ASSERT_NEXT(a_no_instant, in_valid && in_ready, !out_valid, "result too early")
    // A hit and an eviction never come together.
    `LFU_ASSERT_IMP(a_hit_evict, out_valid, !(out_item.hit && out_item.evicted), "hit with evict")
endmodule

bind lfu_replacement_table_core lfu_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

[bench/testbench.sv]
// Self-checking testbench for the LFU replacement table core.
`timescale 1ns / 100ps

import lfu_pkg::*;

// Holds the predicted table and the queue of expected results.
class lfu_scoreboard;
    bit        slot_used [ENTRIES];
    bit [31:0] slot_key [ENTRIES];
    bit [63:0] slot_data [ENTRIES];
    bit [15:0] slot_uses [ENTRIES];
    bit [31:0] slot_stamp [ENTRIES];
    bit [31:0] stamp_now;
    int        fill;
    bit [6:0]  cap_reg;
    out_item_t pending_results[$];
    int        errors;
    int        checked;
    int        evictions;
    int        hits;

    function void clear_table();
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        stamp_now = 0;
        fill = 0;
        cap_reg = 7'd64;
    endfunction

    function void set_capacity(bit [6:0] v);
        cap_reg = v;
    endfunction

    function bit [31:0] take_stamp();
        take_stamp = stamp_now;
        stamp_now = stamp_now + 32'd1;
    endfunction

    function void bump(int s);
        if (slot_uses[s] != 16'hFFFF) slot_uses[s] = slot_uses[s] + 16'd1;
        slot_stamp[s] = take_stamp();
    endfunction

    // Note an accepted input item and work out its result.
    function void note_request(in_item_t it);
        out_item_t r;
        int cap, s, v, f;
        bit [31:0] age, best_age;
        bit [15:0] best_uses;
        r = '0;
        cap = int'(cap_reg);
        if (cap == 0) cap = 1;
        if (cap > ENTRIES) cap = ENTRIES;
        s = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (s < 0 && slot_used[i] && slot_key[i] == it.key_tag) s = i;
        if (it.func == FUNC_GET)
        begin
            if (s >= 0)
            begin
                bump(s);
                r.hit = 1'b1;
                r.read_data = slot_data[s];
            end
        end
        else if (it.func == FUNC_SET)
        begin
            if (s >= 0)
            begin
                bump(s);
                slot_data[s] = it.write_data;
                r.hit = 1'b1;
            end
            else
            begin
                if (fill >= cap)
                begin
                    // Lowest count wins; among ties the oldest stamp, then lowest slot.
                    v = -1;
                    best_uses = 0;
                    best_age = 0;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (slot_used[i])
                        begin
                            age = stamp_now - slot_stamp[i];
                            if (v < 0 || slot_uses[i] < best_uses ||
                                (slot_uses[i] == best_uses && age > best_age))
                            begin
                                v = i;
                                best_uses = slot_uses[i];
                                best_age = age;
                            end
                        end
                    end
                    if (v >= 0)
                    begin
                        r.evicted = 1'b1;
                        r.evicted_key = slot_key[v];
                        r.evicted_data = slot_data[v];
                        slot_used[v] = 1'b0;
                        fill--;
                    end
                end
                f = -1;
                for (int i = 0; i < ENTRIES; i++)
                    if (f < 0 && !slot_used[i]) f = i;
                if (f >= 0)
                begin
                    slot_used[f] = 1'b1;
                    slot_key[f] = it.key_tag;
                    slot_data[f] = it.write_data;
                    slot_uses[f] = (it.start_count == 16'd0) ? 16'd1 : it.start_count;
                    slot_stamp[f] = take_stamp();
                    fill++;
                end
            end
        end
        else if (it.func == FUNC_TAKE)
        begin
            if (s >= 0)
            begin
                r.hit = 1'b1;
                r.read_data = slot_data[s];
                slot_used[s] = 1'b0;
                fill--;
            end
        end
        pending_results = {pending_results, r};
    endfunction

    // Compare one result with the oldest expectation.
    function void check_result(out_item_t got);
        out_item_t exp_r;
        if (pending_results.size() == 0)
        begin
            $error("Result with no expectation waiting");
            errors++;
            return;
        end
        exp_r = pending_results[0];
        pending_results.delete(0);
        checked++;
        if (exp_r.hit) hits++;
        if (exp_r.evicted) evictions++;
        if (got.hit !== exp_r.hit)
        begin
            $error("hit: expected %0h, got %0h", exp_r.hit, got.hit);
            errors++;
        end
        if (got.read_data !== exp_r.read_data)
        begin
            $error("read_data: expected %0h, got %0h", exp_r.read_data, got.read_data);
            errors++;
        end
        if (got.evicted !== exp_r.evicted)
        begin
            $error("evicted: expected %0h, got %0h", exp_r.evicted, got.evicted);
            errors++;
        end
        if (got.evicted_key !== exp_r.evicted_key)
        begin
            $error("evicted_key: expected %0h, got %0h",
                   exp_r.evicted_key, got.evicted_key);
            errors++;
        end
        if (got.evicted_data !== exp_r.evicted_data)
        begin
            $error("evicted_data: expected %0h, got %0h",
                   exp_r.evicted_data, got.evicted_data);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 150;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_item;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_item;
    logic       cfg_we;
    logic [6:0] cfg_wdata;

    lfu_scoreboard table_model;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;
    bit [31:0] key_pool [16];

    lfu_replacement_table_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Receiver: random stalls, checks every accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready) table_model.check_result(out_item);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles with no accepted item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("** lfu_replacement_table_core: FAILED **");
                $finish;
            end
        end
    end

    // Send one item and wait until it is accepted; valid drops only while idling.
    task automatic send_request(bit [1:0] f, bit [31:0] k, bit [63:0] d, bit [15:0] c);
        in_item_t it;
        it.func = f;
        it.key_tag = k;
        it.write_data = d;
        it.start_count = c;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        table_model.note_request(it);
    endtask

    // Wait for all results, then let the block settle before a register write.
    task automatic drain();
        in_valid <= 1'b0;
        while (table_model.pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(bit [6:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        table_model.set_capacity(v);
    endtask

    // Random item, mostly drawn from a small key pool to get hits and evictions.
    task automatic random_request();
        bit [1:0]  f;
        bit [31:0] k;
        bit [15:0] c;
        int sel;
        sel = $urandom_range(99);
        if (sel < 45) f = FUNC_SET;
        else if (sel < 80) f = FUNC_GET;
        else if (sel < 97) f = FUNC_TAKE;
        else f = 2'd3;
        k = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(15)];
        sel = $urandom_range(9);
        if (sel < 6) c = 16'd1;
        else if (sel < 8) c = 16'($urandom_range(4));
        else c = 16'($urandom());
        send_request(f, k, {$urandom(), $urandom()}, c);
    endtask

    initial
    begin
        table_model = new();
        table_model.clear_table();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 7'd0;
        quiet_cycles = 0;
        send_idle_pct = 10;
        recv_idle_pct = 77;
        foreach (key_pool[i]) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: misses, extremes, saturation, unknown op, eviction order.
        send_request(FUNC_GET, 32'h0, 64'h0, 16'd1);
        send_request(FUNC_TAKE, 32'hFFFF_FFFF, 64'h0, 16'd1);
        send_request(FUNC_SET, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
        send_request(FUNC_SET, 32'hFFFF_FFFF, 64'h0, 16'hFFFF);
        send_request(FUNC_GET, 32'hFFFF_FFFF, 64'h0, 16'd1);
        send_request(FUNC_SET, 32'hFFFF_FFFF, 64'h1234, 16'd1);
        send_request(2'd3, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_request(FUNC_GET, 32'h0, 64'h0, 16'd1);
        send_request(FUNC_TAKE, 32'h0, 64'h0, 16'd1);
        send_request(FUNC_GET, 32'h0, 64'h0, 16'd1);
        write_capacity(7'd2);
        send_request(FUNC_SET, 32'hA, 64'hA, 16'd1);
        send_request(FUNC_SET, 32'hB, 64'hB, 16'd1);
        send_request(FUNC_SET, 32'hC, 64'hC, 16'd1);
        send_request(FUNC_GET, 32'hB, 64'h0, 16'd1);
        send_request(FUNC_SET, 32'hD, 64'hD, 16'd2);
        send_request(FUNC_SET, 32'hE, 64'hE, 16'd1);
        write_capacity(7'd0);
        send_request(FUNC_SET, 32'hF, 64'hF, 16'd1);
        send_request(FUNC_SET, 32'h10, 64'h10, 16'd1);
        write_capacity(7'd127);
        send_request(FUNC_SET, 32'h11, 64'h11, 16'd3);
        write_capacity(7'd1);

        // Random part in three idling phases and several capacity settings.
        for (int n = 0; n < 850; n++)
        begin
            if (n == 280)
            begin
                send_idle_pct = 77;
                recv_idle_pct = 10;
            end
            if (n == 560)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (n % 100 == 50)
            begin
                case ($urandom_range(4))
                    0: write_capacity(7'd1);
                    1: write_capacity(7'd64);
                    2: write_capacity(7'd100);
                    3: write_capacity(7'd0);
                    default: write_capacity(7'($urandom_range(2, 12)));
                endcase
            end
            random_request();
        end

        drain();
        $display("Checked %0d results: %0d hits, %0d evictions.",
                 table_model.checked, table_model.hits, table_model.evictions);
        if (table_model.errors == 0 && table_model.pending_results.size() == 0)
            $display("** lfu_replacement_table_core: PASSED **");
        else
            $display("** lfu_replacement_table_core: FAILED **");
        $finish;
    end
endmodule
